// ===== rtl/dtd_pkg.sv =====
// Package for the DNS-over-TCP length-prefix deframer.
// Holds the field widths, beat payload structs and status and request codes.
// No dependencies; every other file of the block imports it.
package dtd_pkg;

    localparam int MESSAGE_COUNT_BITS = 20;
    localparam int MSG_NUM_W          = 20;
    localparam int MAX_MSG_W          = 20;
    localparam int SEQ_W              = 32;
    localparam int LEN_W              = 16;

    localparam logic [MAX_MSG_W-1:0] MAX_MESSAGES_RESET = MAX_MSG_W'(1024);
    localparam logic [LEN_W-1:0]     MIN_FRAME_LEN      = LEN_W'(12);

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    localparam logic [1:0] UPS_CONFLICT = 2'd1;
    localparam logic [1:0] UPS_LIMIT    = 2'd2;

    localparam logic [2:0] ST_COMPLETE   = 3'd0;
    localparam logic [2:0] ST_CONFLICT   = 3'd1;
    localparam logic [2:0] ST_LIMIT      = 3'd2;
    localparam logic [2:0] ST_UNANCHORED = 3'd3;
    localparam logic [2:0] ST_INVALID    = 3'd4;
    localparam logic [2:0] ST_GAP        = 3'd5;
    localparam logic [2:0] ST_TAIL       = 3'd6;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       data_byte;
        logic             syn_flag;
        logic [1:0]       upstream_status;
        logic [SEQ_W-1:0] base_sequence;
        logic [SEQ_W-1:0] expected_length;
        logic             gap_seen;
    } t_in_item;

    typedef struct packed {
        logic                 is_diagnostic;
        logic [2:0]           status;
        logic [7:0]           payload_byte;
        logic [MSG_NUM_W-1:0] msg_index;
        logic [SEQ_W-1:0]     frame_sequence;
        logic                 last_of_message;
    } t_out_item;

endpackage

// ===== rtl/dtd_in_if.sv =====
// Input channel of the deframer: valid/ready handshake with the stream item fields.
// Depends on dtd_pkg for the field widths.
interface dtd_in_if;
    import dtd_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [7:0]       data_byte;
    logic             syn_flag;
    logic [1:0]       upstream_status;
    logic [SEQ_W-1:0] base_sequence;
    logic [SEQ_W-1:0] expected_length;
    logic             gap_seen;

    modport source (
        output valid, req_type, data_byte, syn_flag, upstream_status,
               base_sequence, expected_length, gap_seen,
        input  ready
    );
    modport sink (
        input  valid, req_type, data_byte, syn_flag, upstream_status,
               base_sequence, expected_length, gap_seen,
        output ready
    );
endinterface

// ===== rtl/dtd_out_if.sv =====
// Output channel of the deframer: valid/ready handshake with the result fields.
// Depends on dtd_pkg for the field widths.
interface dtd_out_if;
    import dtd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 is_diagnostic;
    logic [2:0]           status;
    logic [7:0]           payload_byte;
    logic [MSG_NUM_W-1:0] msg_index;
    logic [SEQ_W-1:0]     frame_sequence;
    logic                 last_of_message;

    modport source (
        output valid, is_diagnostic, status, payload_byte, msg_index,
               frame_sequence, last_of_message,
        input  ready
    );
    modport sink (
        input  valid, is_diagnostic, status, payload_byte, msg_index,
               frame_sequence, last_of_message,
        output ready
    );
endinterface

// ===== rtl/dtd_in_reg.sv =====
// Input register of the deframer: takes one beat and holds it until the engine consumes it.
// Depends on dtd_pkg and dtd_in_if.
module dtd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dtd_in_if.sink            i_in,
    input  logic              i_advance,
    output logic              o_valid,
    output dtd_pkg::t_in_item o_item
);
    import dtd_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     take;

    assign i_in.ready = !r_valid || i_advance;
    assign take       = i_in.valid && i_in.ready;
    assign n_valid    = take || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.req_type        <= i_in.req_type;
            r_item.data_byte       <= i_in.data_byte;
            r_item.syn_flag        <= i_in.syn_flag;
            r_item.upstream_status <= i_in.upstream_status;
            r_item.base_sequence   <= i_in.base_sequence;
            r_item.expected_length <= i_in.expected_length;
            r_item.gap_seen        <= i_in.gap_seen;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== rtl/dtd_engine.sv =====
// Framing engine: stream state, the message limit register and the per-beat decision.
// Depends on dtd_pkg.
module dtd_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtd_pkg::MAX_MSG_W-1:0] i_cfg_data,
    input  logic                          i_fire,
    input  dtd_pkg::t_in_item             i_item,
    output logic                          o_has_result,
    output dtd_pkg::t_out_item            o_result
);
    import dtd_pkg::*;

    localparam int CNT_W = MESSAGE_COUNT_BITS;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [MAX_MSG_W-1:0] r_max_messages;
    logic [2:0]           r_phase,        n_phase;
    logic [7:0]           r_length_high,  n_length_high;
    logic [LEN_W-1:0]     r_remaining,    n_remaining;
    logic [CNT_W-1:0]     r_count,        n_count;
    logic [SEQ_W-1:0]     r_fso,          n_fso;
    logic [SEQ_W-1:0]     r_consumed,     n_consumed;
    logic [SEQ_W-1:0]     r_base,         n_base;
    logic                 r_over_limit,   n_over_limit;

    logic [SEQ_W-1:0]     frame_seq;
    logic [SEQ_W-1:0]     consumed_inc;
    logic [LEN_W-1:0]     frame_len;
    logic [LEN_W-1:0]     remaining_dec;
    logic                 last;
    logic [CNT_W:0]       count_plus;
    logic                 at_limit;

    assign frame_seq     = r_base + r_fso;
    assign consumed_inc  = r_consumed + SEQ_W'(1);
    assign frame_len     = {r_length_high, i_item.data_byte};
    assign remaining_dec = r_remaining - LEN_W'(1);
    assign last          = (remaining_dec == '0);
    assign count_plus    = (CNT_W+1)'(r_count) + (CNT_W+1)'(1);
    assign at_limit      = 33'(r_count) >= 33'(r_max_messages);

    always_comb begin
        n_phase       = r_phase;
        n_length_high = r_length_high;
        n_remaining   = r_remaining;
        n_count       = r_count;
        n_fso         = r_fso;
        n_consumed    = r_consumed;
        n_base        = r_base;
        n_over_limit  = r_over_limit;

        o_has_result              = 1'b0;
        o_result.is_diagnostic    = 1'b1;
        o_result.status           = ST_COMPLETE;
        o_result.payload_byte     = 8'd0;
        o_result.msg_index        = '0;
        o_result.frame_sequence   = frame_seq;
        o_result.last_of_message  = 1'b0;

        case (i_item.req_type)
            REQ_START: begin
                n_length_high = 8'd0;
                n_remaining   = '0;
                n_count       = '0;
                n_fso         = '0;
                n_consumed    = '0;
                n_over_limit  = 1'b0;
                n_base        = i_item.base_sequence;
                o_result.frame_sequence = i_item.base_sequence;
                if (i_item.upstream_status == UPS_CONFLICT ||
                    i_item.upstream_status == UPS_LIMIT) begin
                    o_has_result    = 1'b1;
                    o_result.status = (i_item.upstream_status == UPS_CONFLICT) ?
                                      ST_CONFLICT : ST_LIMIT;
                    n_phase         = PH_DONE;
                end else if (!i_item.syn_flag) begin
                    o_has_result    = 1'b1;
                    o_result.status = ST_UNANCHORED;
                    n_phase         = PH_DONE;
                end else begin
                    n_phase = PH_LEN_HI;
                end
            end
            REQ_BYTE: begin
                case (r_phase)
                    PH_LEN_HI: begin
                        n_consumed    = consumed_inc;
                        n_length_high = i_item.data_byte;
                        n_phase       = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_consumed = consumed_inc;
                        if (frame_len < MIN_FRAME_LEN) begin
                            o_has_result    = 1'b1;
                            o_result.status = ST_INVALID;
                            n_phase         = PH_DONE;
                        end else begin
                            n_remaining  = frame_len;
                            n_over_limit = at_limit;
                            n_phase      = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        n_consumed  = consumed_inc;
                        n_remaining = remaining_dec;
                        if (r_over_limit) begin
                            // Suppressed frame: only its completion is reported.
                            if (last) begin
                                o_has_result            = 1'b1;
                                o_result.status         = ST_LIMIT;
                                o_result.frame_sequence = r_base;
                                n_phase                 = PH_DONE;
                            end
                        end else begin
                            o_has_result             = 1'b1;
                            o_result.is_diagnostic   = 1'b0;
                            o_result.payload_byte    = i_item.data_byte;
                            o_result.msg_index       = MSG_NUM_W'(count_plus);
                            o_result.last_of_message = last;
                            if (last) begin
                                if (r_count != '1) begin
                                    n_count = count_plus[CNT_W-1:0];
                                end
                                n_fso   = consumed_inc;
                                n_phase = PH_LEN_HI;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_END: begin
                if (r_phase == PH_LEN_HI || r_phase == PH_LEN_LO ||
                    r_phase == PH_BODY || r_phase == PH_DONE) begin
                    n_phase       = PH_IDLE;
                    n_length_high = 8'd0;
                    n_remaining   = '0;
                    n_count       = '0;
                    n_fso         = '0;
                    n_consumed    = '0;
                    n_base        = '0;
                    n_over_limit  = 1'b0;
                    if (r_phase != PH_DONE && r_fso != i_item.expected_length) begin
                        o_has_result    = 1'b1;
                        o_result.status = i_item.gap_seen ? ST_GAP : ST_TAIL;
                    end
                end
            end
            default: begin
            end
        endcase

        if (!i_fire) begin
            o_has_result = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_messages <= MAX_MESSAGES_RESET;
            r_phase        <= PH_IDLE;
            r_length_high  <= 8'd0;
            r_remaining    <= '0;
            r_count        <= '0;
            r_fso          <= '0;
            r_consumed     <= '0;
            r_base         <= '0;
            r_over_limit   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_messages <= i_cfg_data;
            end
            if (i_fire) begin
                r_phase       <= n_phase;
                r_length_high <= n_length_high;
                r_remaining   <= n_remaining;
                r_count       <= n_count;
                r_fso         <= n_fso;
                r_consumed    <= n_consumed;
                r_base        <= n_base;
                r_over_limit  <= n_over_limit;
            end
        end
    end
endmodule

// ===== rtl/dtd_out_reg.sv =====
// Result register of the deframer: holds one result beat until the sink takes it.
// Depends on dtd_pkg and dtd_out_if.
module dtd_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  dtd_pkg::t_out_item i_result,
    output logic               o_free,
    dtd_out_if.source          o_out
);
    import dtd_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_result;

    assign o_free  = !r_valid || o_out.ready;
    assign n_valid = i_load || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.is_diagnostic   = r_result.is_diagnostic;
    assign o_out.status          = r_result.status;
    assign o_out.payload_byte    = r_result.payload_byte;
    assign o_out.msg_index       = r_result.msg_index;
    assign o_out.frame_sequence  = r_result.frame_sequence;
    assign o_out.last_of_message = r_result.last_of_message;
endmodule

// ===== rtl/dns_tcp_length_prefix_deframer_core.sv =====
// DNS-over-TCP length-prefix deframer: splits one stream direction into DNS messages.
// Each accepted beat is held in the input register, its result in the result register;
// one beat is accepted every cycle while the output keeps up.
// Synchronous active-low reset returns the stream to idle with all counters cleared
// and the message limit at 1024. Depends on dtd_pkg, the two channel interfaces and
// dtd_in_reg, dtd_engine, dtd_out_reg.
module dns_tcp_length_prefix_deframer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtd_pkg::MAX_MSG_W-1:0] i_cfg_data,
    dtd_in_if.sink                        i_in,
    dtd_out_if.source                     o_out
);
    import dtd_pkg::*;

    logic      item_valid;
    t_in_item  item;
    logic      out_free;
    logic      advance;
    logic      has_result;
    t_out_item result;

    // The held beat moves on whenever the result register can take whatever it produces.
    assign advance = item_valid && out_free;

    dtd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    dtd_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (advance),
        .i_item       (item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    dtd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (has_result),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );
endmodule

// ===== rtl/dtd_checker.sv =====
// Port-level checks for the deframer core, attached to it by the bind at the end.
// Depends on dtd_pkg.
module dtd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_is_diagnostic,
    input logic [2:0]                    i_status,
    input logic [7:0]                    i_payload_byte,
    input logic [dtd_pkg::MSG_NUM_W-1:0] i_msg_index,
    input logic                          i_last_of_message
);
    import dtd_pkg::*;

    // A result beat left waiting stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result offered straight after reset");

    // Message bytes carry the complete status and a non-zero message number.
    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_is_diagnostic) |->
        (i_status == ST_COMPLETE && i_msg_index != '0))
        else $error("message byte with bad status or number");

    // Diagnostics carry no byte, no message number and no end marker.
    a_diag_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_diagnostic) |->
        (i_payload_byte == 8'd0 && i_msg_index == '0 && !i_last_of_message &&
         i_status != ST_COMPLETE))
        else $error("diagnostic with message fields set");
endmodule

bind dns_tcp_length_prefix_deframer_core dtd_checker u_dtd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_is_diagnostic   (o_out.is_diagnostic),
    .i_status          (o_out.status),
    .i_payload_byte    (o_out.payload_byte),
    .i_msg_index       (o_out.msg_index),
    .i_last_of_message (o_out.last_of_message)
);
